### src/otsu_threshold_macros.svh
// Assertion macros shared by the otsu_threshold RTL.
// Each macro expects clk_i and rst_ni to be visible in the enclosing module.
`ifndef OTSU_THRESHOLD_MACROS_SVH
`define OTSU_THRESHOLD_MACROS_SVH

// The condition must hold in the same cycle as the trigger.
`define OTSU_ASSERT_SAME(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// The condition must hold in the cycle after the trigger.
`define OTSU_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

### src/otsu_pkg.sv
// Shared types and constants for the otsu_threshold block.
// No dependencies; used by the controller, the datapath and the top level.
`default_nettype none

package otsu_pkg;

  // Gray levels and the width of a level index.
  localparam int unsigned LEVELS = 256;
  localparam int unsigned LVL_W  = 8;

  // Operations of the shared serial multiplier.
  typedef enum logic [2:0] {
    MUL_SW,   // total sum times w
    MUL_SN,   // partial sum times pixel count
    MUL_DEN,  // w times (N - w)
    MUL_D2,   // difference squared
    MUL_LHS,  // difference squared times best denominator
    MUL_RHS   // best difference squared times denominator
  } mul_op_e;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic    accept;
    logic    rd_sweep;
    logic    sw_init;
    logic    sw_add;
    logic    mul_start;
    mul_op_e mul_op;
    logic    cap_a;
    logic    cap_b;
    logic    cap_den;
    logic    cap_d2;
    logic    cap_lhs;
    logic    best_chk;
    logic    t_inc;
    logic    out_load;
  } otsu_cmd_t;

  // Status from the datapath to the controller.
  typedef struct packed {
    logic h_nz;
    logic w_zero;
    logic w_full;
    logic mul_done;
    logic t_last;
    logic out_free;
  } otsu_sts_t;

endpackage

`default_nettype wire

### src/otsu_ram.sv
// Generic single-write, single-read RAM with a registered read port.
// No dependencies.
`default_nettype none

module otsu_ram #(
  parameter int unsigned WIDTH = 17,
  parameter int unsigned DEPTH = 256
) (
  input  wire logic                     clk_i,
  input  wire logic                     we_i,
  input  wire logic [$clog2(DEPTH)-1:0] waddr_i,
  input  wire logic [WIDTH-1:0]         wdata_i,
  input  wire logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic      [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  // Write port and registered read port; a read of the address being
  // written returns the old contents.
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
    rdata_q <= mem[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule

`default_nettype wire

### src/otsu_mul.sv
// Shift-and-add multiplier that retires one bit of the Y operand per cycle.
// No dependencies; instantiated by the datapath.
`default_nettype none

module otsu_mul #(
  parameter int unsigned XW = 84,
  parameter int unsigned YW = 42
) (
  input  wire logic             clk_i,
  input  wire logic             rst_ni,
  input  wire logic             start_i,
  input  wire logic [XW-1:0]    x_i,
  input  wire logic [YW-1:0]    y_i,
  output logic                  done_o,
  output logic      [XW+YW-1:0] prod_o
);

  localparam int unsigned PW = XW + YW;

  logic          busy_q;
  logic [PW-1:0] x_q;
  logic [YW-1:0] y_q;
  logic [PW-1:0] acc_q;

  // Busy flag: set on start, stays set so that done holds until restart.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
    end else if (start_i) begin
      busy_q <= 1'b1;
    end
  end

  // Operand shifting and accumulation; stops once Y has no bits left.
  always_ff @(posedge clk_i) begin
    if (start_i) begin
      x_q   <= PW'(x_i);
      y_q   <= y_i;
      acc_q <= '0;
    end else if (busy_q && (y_q != '0)) begin
      if (y_q[0]) begin
        acc_q <= acc_q + x_q;
      end
      x_q <= x_q << 1;
      y_q <= y_q >> 1;
    end
  end

  assign done_o = busy_q && (y_q == '0);
  assign prod_o = acc_q;

endmodule

`default_nettype wire

### src/otsu_dp.sv
// Datapath: histogram RAM with read-modify-write, frame totals, sweep
// accumulators, the serial multiplier and the result register.
// Depends on otsu_pkg, otsu_ram, otsu_mul and otsu_threshold_macros.svh.
`default_nettype none
`include "otsu_threshold_macros.svh"

module otsu_dp import otsu_pkg::*; #(
  parameter int unsigned MAX_PIXELS = 65536
) (
  input  wire logic             clk_i,
  input  wire logic             rst_ni,
  input  wire otsu_cmd_t        cmd_i,
  output otsu_sts_t             sts_o,
  input  wire logic [LVL_W-1:0] pixel_i,
  input  wire logic             out_stall_i,
  output logic                  out_valid_o,
  output logic      [LVL_W-1:0] threshold_o
);

  localparam int unsigned CNT_W = $clog2(MAX_PIXELS + 1);
  localparam int unsigned SUM_W = CNT_W + LVL_W;
  localparam int unsigned DW    = SUM_W + CNT_W;
  localparam int unsigned DEN_W = 2 * CNT_W;
  localparam int unsigned D2_W  = 2 * DW;
  localparam int unsigned XW    = D2_W;
  localparam int unsigned YW    = DW;
  localparam int unsigned PW    = XW + YW;

  // Frame totals and the update stage of the histogram.
  logic [CNT_W-1:0] cnt_q;
  logic [SUM_W-1:0] sum_q;
  logic             a_vld_q;
  logic [LVL_W-1:0] a_addr_q;
  logic             wr_fwd_q;
  logic [LVL_W-1:0] wr_addr_q;
  logic [CNT_W-1:0] wr_data_q;
  logic [LEVELS-1:0] vld_q;
  logic             vld_rd_q;

  logic [LVL_W-1:0] ram_raddr;
  logic [CNT_W-1:0] ram_rdata;
  logic [CNT_W-1:0] hist_rd;
  logic [CNT_W-1:0] hist_wdata;
  logic             count_ok;
  logic             fwd_hit;

  // Sweep state.
  logic [LVL_W-1:0] t_q;
  logic [CNT_W-1:0] w_q;
  logic [SUM_W-1:0] s_q;
  logic             h_nz_q;
  logic [DW-1:0]    a_q;
  logic [DW-1:0]    d_q;
  logic [DEN_W-1:0] den_q;
  logic [D2_W-1:0]  d2_q;
  logic [PW-1:0]    lhs_q;
  logic [D2_W-1:0]  best_d2_q;
  logic [DEN_W-1:0] best_den_q;
  logic [LVL_W-1:0] best_t_q;

  logic [XW-1:0]    mul_x;
  logic [YW-1:0]    mul_y;
  logic [PW-1:0]    mul_prod;
  logic             mul_done;
  logic [DW-1:0]    b_val;

  // Output register.
  logic             out_valid_q;
  logic [LVL_W-1:0] thr_q;

  assign count_ok  = cnt_q < CNT_W'(MAX_PIXELS);
  assign ram_raddr = cmd_i.rd_sweep ? t_q : pixel_i;

  // A bin written on the previous edge is not yet visible in the read data.
  assign fwd_hit    = wr_fwd_q && (wr_addr_q == a_addr_q);
  assign hist_rd    = fwd_hit ? wr_data_q : (vld_rd_q ? ram_rdata : '0);
  assign hist_wdata = hist_rd + CNT_W'(1);

  otsu_ram #(
    .WIDTH (CNT_W),
    .DEPTH (LEVELS)
  ) u_hist (
    .clk_i   (clk_i),
    .we_i    (a_vld_q),
    .waddr_i (a_addr_q),
    .wdata_i (hist_wdata),
    .raddr_i (ram_raddr),
    .rdata_o (ram_rdata)
  );

  // Pixel count, gray sum, bin valid bits and the update pipeline.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q    <= '0;
      sum_q    <= '0;
      a_vld_q  <= 1'b0;
      wr_fwd_q <= 1'b0;
      vld_q    <= '0;
    end else begin
      a_vld_q  <= cmd_i.accept && count_ok;
      wr_fwd_q <= a_vld_q;
      if (cmd_i.out_load) begin
        cnt_q <= '0;
        sum_q <= '0;
        vld_q <= '0;
      end else begin
        if (cmd_i.accept && count_ok) begin
          cnt_q <= cnt_q + CNT_W'(1);
          sum_q <= sum_q + SUM_W'(pixel_i);
        end
        if (a_vld_q) begin
          vld_q[a_addr_q] <= 1'b1;
        end
      end
    end
  end

  // Address and data that follow the read-modify-write.
  always_ff @(posedge clk_i) begin
    a_addr_q  <= pixel_i;
    wr_addr_q <= a_addr_q;
    wr_data_q <= hist_wdata;
    vld_rd_q  <= vld_q[ram_raddr];
  end

  // Operand selection for the serial multiplier.
  always_comb begin
    unique case (cmd_i.mul_op)
      MUL_SW: begin
        mul_x = XW'(sum_q);
        mul_y = YW'(w_q);
      end
      MUL_SN: begin
        mul_x = XW'(s_q);
        mul_y = YW'(cnt_q);
      end
      MUL_DEN: begin
        mul_x = XW'(w_q);
        mul_y = YW'(cnt_q - w_q);
      end
      MUL_D2: begin
        mul_x = XW'(d_q);
        mul_y = d_q;
      end
      MUL_LHS: begin
        // The square is still on the product output when this multiply starts.
        mul_x = mul_prod[D2_W-1:0];
        mul_y = YW'(best_den_q);
      end
      MUL_RHS: begin
        mul_x = best_d2_q;
        mul_y = YW'(den_q);
      end
      default: begin
        mul_x = '0;
        mul_y = '0;
      end
    endcase
  end

  otsu_mul #(
    .XW (XW),
    .YW (YW)
  ) u_mul (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (cmd_i.mul_start),
    .x_i     (mul_x),
    .y_i     (mul_y),
    .done_o  (mul_done),
    .prod_o  (mul_prod)
  );

  assign b_val = mul_prod[DW-1:0];

  // Sweep accumulators, variance terms and the running best level.
  always_ff @(posedge clk_i) begin
    if (cmd_i.sw_init) begin
      t_q        <= '0;
      w_q        <= '0;
      s_q        <= '0;
      best_d2_q  <= '0;
      best_den_q <= DEN_W'(1);
      best_t_q   <= '0;
    end else begin
      if (cmd_i.sw_add) begin
        w_q    <= w_q + hist_rd;
        s_q    <= s_q + (SUM_W'(t_q) * SUM_W'(hist_rd));
        h_nz_q <= hist_rd != '0;
      end
      if (cmd_i.t_inc) begin
        t_q <= t_q + LVL_W'(1);
      end
      if (cmd_i.best_chk && (lhs_q > mul_prod)) begin
        best_d2_q  <= d2_q;
        best_den_q <= den_q;
        best_t_q   <= t_q;
      end
    end
    if (cmd_i.cap_a) begin
      a_q <= mul_prod[DW-1:0];
    end
    if (cmd_i.cap_b) begin
      d_q <= (a_q >= b_val) ? (a_q - b_val) : (b_val - a_q);
    end
    if (cmd_i.cap_den) begin
      den_q <= mul_prod[DEN_W-1:0];
    end
    if (cmd_i.cap_d2) begin
      d2_q <= mul_prod[D2_W-1:0];
    end
    if (cmd_i.cap_lhs) begin
      lhs_q <= mul_prod;
    end
  end

  // Result beat: loaded at the end of the sweep, held while stalled.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (cmd_i.out_load) begin
      out_valid_q <= 1'b1;
    end else if (!out_stall_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.out_load) begin
      thr_q <= best_t_q;
    end
  end

  assign out_valid_o = out_valid_q;
  assign threshold_o = thr_q;

  // Status back to the controller.
  assign sts_o.h_nz     = h_nz_q;
  assign sts_o.w_zero   = w_q == '0;
  assign sts_o.w_full   = w_q >= cnt_q;
  assign sts_o.mul_done = mul_done;
  assign sts_o.t_last   = t_q == LVL_W'(LEVELS - 1);
  assign sts_o.out_free = !out_valid_q || !out_stall_i;

  // The frame count never runs past its limit.
  `OTSU_ASSERT_SAME(a_cnt_bound, 1'b1, cnt_q <= CNT_W'(MAX_PIXELS), "pixel count over limit")
  // Both denominators of the comparison are nonzero when it is made.
  `OTSU_ASSERT_SAME(a_den_nz, cmd_i.best_chk, (best_den_q != '0) && (den_q != '0), "zero denominator")
  // No histogram update is in flight while the sweep reads the RAM.
  `OTSU_ASSERT_SAME(a_no_upd_sweep, cmd_i.rd_sweep || cmd_i.sw_add, !a_vld_q, "update during sweep")

endmodule

`default_nettype wire

### src/otsu_ctrl.sv
// Controller: accepts pixel beats, then sequences the level sweep and the
// multiplier operations. Depends on otsu_pkg and otsu_threshold_macros.svh.
`default_nettype none
`include "otsu_threshold_macros.svh"

module otsu_ctrl import otsu_pkg::*; (
  input  wire logic      clk_i,
  input  wire logic      rst_ni,
  input  wire logic      in_valid_i,
  input  wire logic      last_pixel_i,
  output logic           in_stall_o,
  input  wire otsu_sts_t sts_i,
  output otsu_cmd_t      cmd_o
);

  typedef enum logic [3:0] {
    ST_ACCUM,
    ST_DRAIN,
    ST_READ,
    ST_ADD,
    ST_CHECK,
    ST_MUL_SW,
    ST_MUL_SN,
    ST_MUL_DEN,
    ST_MUL_D2,
    ST_MUL_LHS,
    ST_MUL_RHS,
    ST_NEXT,
    ST_OUT
  } state_e;

  state_e state_q;
  logic   stall_q;
  logic   accept;
  logic   evaluate;

  assign accept   = in_valid_i && !stall_q;
  assign evaluate = sts_i.h_nz && !sts_i.w_zero && !sts_i.w_full;

  // State register and the registered input stall.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_ACCUM;
      stall_q <= 1'b0;
    end else begin
      unique case (state_q)
        ST_ACCUM: begin
          if (accept && last_pixel_i) begin
            state_q <= ST_DRAIN;
            stall_q <= 1'b1;
          end
        end
        ST_DRAIN: state_q <= ST_READ;
        ST_READ:  state_q <= ST_ADD;
        ST_ADD:   state_q <= ST_CHECK;
        ST_CHECK: state_q <= evaluate ? ST_MUL_SW : ST_NEXT;
        ST_MUL_SW: begin
          if (sts_i.mul_done) state_q <= ST_MUL_SN;
        end
        ST_MUL_SN: begin
          if (sts_i.mul_done) state_q <= ST_MUL_DEN;
        end
        ST_MUL_DEN: begin
          if (sts_i.mul_done) state_q <= ST_MUL_D2;
        end
        ST_MUL_D2: begin
          if (sts_i.mul_done) state_q <= ST_MUL_LHS;
        end
        ST_MUL_LHS: begin
          if (sts_i.mul_done) state_q <= ST_MUL_RHS;
        end
        ST_MUL_RHS: begin
          if (sts_i.mul_done) state_q <= ST_NEXT;
        end
        ST_NEXT: state_q <= sts_i.t_last ? ST_OUT : ST_READ;
        ST_OUT: begin
          if (sts_i.out_free) begin
            state_q <= ST_ACCUM;
            stall_q <= 1'b0;
          end
        end
        default: begin
          state_q <= ST_ACCUM;
          stall_q <= 1'b0;
        end
      endcase
    end
  end

  // Command decode from the current state and the datapath status.
  always_comb begin
    cmd_o           = '0;
    cmd_o.mul_op    = MUL_SW;
    cmd_o.accept    = accept;
    cmd_o.rd_sweep  = state_q == ST_READ;
    cmd_o.sw_init   = state_q == ST_DRAIN;
    cmd_o.sw_add    = state_q == ST_ADD;
    cmd_o.t_inc     = (state_q == ST_NEXT) && !sts_i.t_last;
    cmd_o.out_load  = (state_q == ST_OUT) && sts_i.out_free;
    unique case (state_q)
      ST_CHECK: begin
        cmd_o.mul_start = evaluate;
        cmd_o.mul_op    = MUL_SW;
      end
      ST_MUL_SW: begin
        cmd_o.cap_a     = sts_i.mul_done;
        cmd_o.mul_start = sts_i.mul_done;
        cmd_o.mul_op    = MUL_SN;
      end
      ST_MUL_SN: begin
        cmd_o.cap_b     = sts_i.mul_done;
        cmd_o.mul_start = sts_i.mul_done;
        cmd_o.mul_op    = MUL_DEN;
      end
      ST_MUL_DEN: begin
        cmd_o.cap_den   = sts_i.mul_done;
        cmd_o.mul_start = sts_i.mul_done;
        cmd_o.mul_op    = MUL_D2;
      end
      ST_MUL_D2: begin
        cmd_o.cap_d2    = sts_i.mul_done;
        cmd_o.mul_start = sts_i.mul_done;
        cmd_o.mul_op    = MUL_LHS;
      end
      ST_MUL_LHS: begin
        cmd_o.cap_lhs   = sts_i.mul_done;
        cmd_o.mul_start = sts_i.mul_done;
        cmd_o.mul_op    = MUL_RHS;
      end
      ST_MUL_RHS: begin
        cmd_o.best_chk  = sts_i.mul_done;
        cmd_o.mul_op    = MUL_RHS;
      end
      default: begin
        cmd_o.mul_start = 1'b0;
      end
    endcase
  end

  assign in_stall_o = stall_q;

  // The input closes right after the frame's final beat.
  `OTSU_ASSERT_NEXT(a_last_stalls, accept && last_pixel_i, in_stall_o, "input open after last beat")
  // The sweep is set up right after the frame's final beat.
  `OTSU_ASSERT_NEXT(a_init_after_last, accept && last_pixel_i, cmd_o.sw_init, "sweep not started")
  // The multiplier stays idle while pixels are being counted.
  `OTSU_ASSERT_SAME(a_no_mul_accum, !in_stall_o, !cmd_o.mul_start, "multiply while counting")

endmodule

`default_nettype wire

### src/otsu_threshold.sv
// Pixels: one beat per cycle, never stalled while a frame is being counted.
// After the last-pixel beat: a drain state, then READ, ADD, CHECK and NEXT per gray level.
// For each level with a nonzero bin and 0 < w < N, six serial multiplies on a Y operand of
// at most 2*ceil(log2(MAX_PIXELS+1))+8 bits run from CHECK to NEXT on the single shift-add
// multiplier. The result register is loaded once it is free; the next frame then streams in.
// Reset clears the bin valid bits, pixel count and gray sum at once: no clearing pass.
`default_nettype none

module otsu_threshold import otsu_pkg::*; #(
  parameter int unsigned MAX_PIXELS = 65536
) (
  input  wire logic             clk_i,
  input  wire logic             rst_ni,
  input  wire logic             in_valid_i,
  output logic                  in_stall_o,
  input  wire logic [LVL_W-1:0] pixel_i,
  input  wire logic             last_pixel_i,
  output logic                  out_valid_o,
  input  wire logic             out_stall_i,
  output logic      [LVL_W-1:0] threshold_o
);

  otsu_cmd_t cmd;
  otsu_sts_t sts;

  // Sequencer for counting and the level sweep.
  otsu_ctrl u_ctrl (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .in_valid_i   (in_valid_i),
    .last_pixel_i (last_pixel_i),
    .in_stall_o   (in_stall_o),
    .sts_i        (sts),
    .cmd_o        (cmd)
  );

  // Histogram, arithmetic and result register.
  otsu_dp #(
    .MAX_PIXELS (MAX_PIXELS)
  ) u_dp (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cmd_i       (cmd),
    .sts_o       (sts),
    .pixel_i     (pixel_i),
    .out_stall_i (out_stall_i),
    .out_valid_o (out_valid_o),
    .threshold_o (threshold_o)
  );

endmodule

`default_nettype wire

### bench/otsu_threshold_checker.sv
// Checker for otsu_threshold: watches the pixel and threshold channels.
// It predicts the threshold of each frame and counts mismatches.
// Depends on otsu_pkg for the level count and the level width.
module otsu_threshold_checker import otsu_pkg::*; #(
  parameter int unsigned MAX_PIXELS = 65536
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             in_valid_i,
  input  logic             in_stall_i,
  input  logic [LVL_W-1:0] pixel_i,
  input  logic             last_pixel_i,
  input  logic             out_valid_i,
  input  logic             out_stall_i,
  input  logic [LVL_W-1:0] threshold_i,
  output int               fail_count_o,
  output int               pending_o
);

  // Frame statistics as the block should hold them.
  logic [16:0]      bin_count [LEVELS];
  logic [16:0]      pixel_count;
  logic [24:0]      gray_total;

  // Thresholds predicted but not yet seen on the output.
  logic [LVL_W-1:0] level_q [$];
  logic [LVL_W-1:0] want_level;
  int               errors;

  // Empty the histogram, the count and the sum.
  task automatic clear_frame();
    for (int i = 0; i < LEVELS; i++) begin
      bin_count[i] = '0;
    end
    pixel_count = '0;
    gray_total  = '0;
  endtask

  // Sweep all levels and keep the first one with the strictly largest
  // between-class variance, compared by exact cross-multiplication.
  function automatic logic [LVL_W-1:0] otsu_level();
    logic [127:0]     n, tot, w, s, a, b, d, den, best_d, best_den, lhs, rhs;
    logic [LVL_W-1:0] best_t;
    n        = 128'(pixel_count);
    tot      = 128'(gray_total);
    w        = '0;
    s        = '0;
    best_d   = '0;
    best_den = 128'd1;
    best_t   = '0;
    for (int t = 0; t < LEVELS; t++) begin
      w = w + 128'(bin_count[t]);
      s = s + 128'(bin_count[t]) * 128'(t);
      if (w != 0 && w < n) begin
        a   = tot * w;
        b   = s * n;
        d   = (a > b) ? a - b : b - a;
        den = w * (n - w);
        lhs = d * d * best_den;
        rhs = best_d * best_d * den;
        if (lhs > rhs) begin
          best_d   = d;
          best_den = den;
          best_t   = LVL_W'(t);
        end
      end
    end
    return best_t;
  endfunction

  // Track both channels; the result beat is handled first since it always
  // belongs to an earlier frame than a pixel beat in the same cycle.
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      clear_frame();
      level_q.delete();
      errors = 0;
      fail_count_o <= 0;
      pending_o    <= 0;
    end else begin
      // Result beat against the oldest prediction.
      if (out_valid_i === 1'b1 && out_stall_i === 1'b0) begin
        if (level_q.size() == 0) begin
          if (errors < 10) begin
            $display("unexpected threshold beat: got %0d", threshold_i);
          end
          errors++;
        end else begin
          want_level = level_q.pop_front();
          if (threshold_i !== want_level) begin
            if (errors < 10) begin
              $display("threshold mismatch: expected %0d, got %0d", want_level, threshold_i);
            end
            errors++;
          end
        end
      end

      // Pixel beat: count it unless the frame is already full.
      if (in_valid_i === 1'b1 && in_stall_i === 1'b0) begin
        if (pixel_count < MAX_PIXELS) begin
          bin_count[pixel_i] = bin_count[pixel_i] + 17'd1;
          pixel_count        = pixel_count + 17'd1;
          gray_total         = gray_total + 25'(pixel_i);
        end
        if (last_pixel_i) begin
          level_q.push_back(otsu_level());
          clear_frame();
        end
      end

      fail_count_o <= errors;
      pending_o    <= level_q.size();
    end
  end

endmodule

### bench/tb_otsu_threshold.sv
// Top of the otsu_threshold bench: clock, reset, pixel frames and output stalls.
// Depends on otsu_pkg, the otsu_threshold block and otsu_threshold_checker.
module tb_otsu_threshold import otsu_pkg::*;;

  localparam int unsigned MAX_PIX      = 65536;
  localparam int          RAND_ITEMS   = 1830;
  localparam int          CALM_ITEMS   = 1530;
  localparam int          HOLD_CYCLES  = 12000;
  // Longest sweep: the drain state, the per-level states and six multiplies per level.
  localparam int          DRAIN_CYCLES = 1 + 4 * LEVELS + LEVELS * 6 * (2 * 17 + 8 + 1);
  localparam int          TIMEOUT      = 200_000_000;

  // Shapes of generated frames.
  typedef enum int {
    FR_SPREAD,
    FR_TWO_PEAKS,
    FR_FEW_LEVELS,
    FR_FLAT,
    FR_EXTREME
  } frame_kind_e;

  logic             clk_i        = 1'b0;
  logic             rst_ni       = 1'b0;
  logic             in_valid_i   = 1'b0;
  logic             in_stall_o;
  logic [LVL_W-1:0] pixel_i      = '0;
  logic             last_pixel_i = 1'b0;
  logic             out_valid_o;
  logic             out_stall_i  = 1'b0;
  logic [LVL_W-1:0] threshold_o;

  int               fail_count;
  int               pending;

  // Knobs shared by the pixel side and the result side.
  logic             idle_on  = 1'b1;
  logic             stall_on = 1'b1;
  logic             hold_req = 1'b0;

  // Frame shape parameters picked per frame.
  int               peak_lo, peak_hi, spread, n_levels, flat_px;
  int               few_lvl [4];
  logic [LVL_W-1:0] frame_px [$];
  int               rand_items;
  int               len;

  otsu_threshold #(
    .MAX_PIXELS(MAX_PIX)
  ) i_dut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_stall_o  (in_stall_o),
    .pixel_i     (pixel_i),
    .last_pixel_i(last_pixel_i),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .threshold_o (threshold_o)
  );

  otsu_threshold_checker #(
    .MAX_PIXELS(MAX_PIX)
  ) i_checker (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_stall_i  (in_stall_o),
    .pixel_i     (pixel_i),
    .last_pixel_i(last_pixel_i),
    .out_valid_i (out_valid_o),
    .out_stall_i (out_stall_i),
    .threshold_i (threshold_o),
    .fail_count_o(fail_count),
    .pending_o   (pending)
  );

  // Clock with a period of ten.
  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  // Offer one pixel beat, maybe after an idle burst, and hold it until taken.
  task automatic send_pixel(input logic [LVL_W-1:0] px, input logic last);
    int gap;
    if (idle_on && $urandom_range(0, 7) == 0) begin
      gap = $urandom_range(1, 12);
      in_valid_i <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    in_valid_i   <= 1'b1;
    pixel_i      <= px;
    last_pixel_i <= last;
    do @(posedge clk_i); while (in_stall_o);
  endtask

  // Send the pixels queued in frame_px as one frame.
  task automatic send_list();
    foreach (frame_px[i]) begin
      send_pixel(frame_px[i], i == frame_px.size() - 1);
    end
  endtask

  // Pick fresh shape parameters for the next generated frame.
  task automatic pick_shape();
    peak_lo  = $urandom_range(0, 127);
    peak_hi  = $urandom_range(128, 255);
    spread   = $urandom_range(0, 12);
    n_levels = $urandom_range(2, 4);
    flat_px  = $urandom_range(0, 255);
    for (int k = 0; k < 4; k++) begin
      few_lvl[k] = $urandom_range(0, 255);
    end
  endtask

  // Draw one pixel of the given frame shape.
  function automatic logic [LVL_W-1:0] pick_pixel(input frame_kind_e kind);
    int v;
    case (kind)
      FR_TWO_PEAKS: begin
        v = int'($urandom_range(0, 2 * spread)) - spread;
        v = v + ($urandom_range(0, 1) ? peak_hi : peak_lo);
        if (v < 0) v = 0;
        if (v > 255) v = 255;
      end
      FR_FEW_LEVELS: v = few_lvl[$urandom_range(0, n_levels - 1)];
      FR_FLAT:       v = flat_px;
      FR_EXTREME:    v = $urandom_range(0, 1) ? 255 : 0;
      default:       v = $urandom_range(0, 255);
    endcase
    return LVL_W'(v);
  endfunction

  // Generate and send one frame of n pixels.
  task automatic send_frame(input int n, input frame_kind_e kind);
    pick_shape();
    for (int i = 0; i < n; i++) begin
      send_pixel(pick_pixel(kind), i == n - 1);
    end
  endtask

  // Stop offering beats and wait until every predicted threshold has come out.
  task automatic wait_drained();
    in_valid_i <= 1'b0;
    @(posedge clk_i);
    while (pending != 0) @(posedge clk_i);
  endtask

  // Result side: random stall bursts, plus one long hold on request.
  initial begin : result_side
    int n;
    @(posedge rst_ni);
    forever begin
      @(posedge clk_i);
      if (hold_req) begin
        out_stall_i <= 1'b1;
        repeat (HOLD_CYCLES) @(posedge clk_i);
        out_stall_i <= 1'b0;
        hold_req = 1'b0;
      end else if (stall_on && $urandom_range(0, 5) == 0) begin
        n = $urandom_range(1, 12);
        out_stall_i <= 1'b1;
        repeat (n) @(posedge clk_i);
        out_stall_i <= 1'b0;
      end
    end
  end

  // Pixel side and verdict.
  initial begin : pixel_side
    repeat (4) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Directed frames: single pixels, extremes, uniform, ties, two classes.
    frame_px = '{8'd0};
    send_list();
    frame_px = '{8'd255};
    send_list();
    frame_px = '{8'd0, 8'd255};
    send_list();
    frame_px = '{8'd128, 8'd128, 8'd128};
    send_list();
    frame_px = '{8'd254, 8'd255};
    send_list();
    frame_px = '{8'd5, 8'd6, 8'd7};
    send_list();
    frame_px = '{8'd10, 8'd200, 8'd10, 8'd200};
    send_list();
    frame_px = '{8'd0, 8'd1, 8'd254, 8'd255};
    send_list();
    frame_px = '{8'd85, 8'd170, 8'd255};
    send_list();
    wait_drained();

    // Long output hold while short frames keep coming, so the block backs up.
    rand_items = 0;
    hold_req = 1'b1;
    for (int f = 0; f < 6; f++) begin
      send_frame(8, frame_kind_e'($urandom_range(0, 4)));
      rand_items += 8;
    end
    wait_drained();

    // Random frames, mostly short; the tail runs without idling or stalls.
    while (rand_items < RAND_ITEMS) begin
      if (rand_items >= CALM_ITEMS) begin
        idle_on  = 1'b0;
        stall_on = 1'b0;
      end
      len = ($urandom_range(0, 9) == 0) ? $urandom_range(25, 64) : $urandom_range(1, 24);
      send_frame(len, frame_kind_e'($urandom_range(0, 4)));
      rand_items += len;
    end

    wait_drained();
    repeat (DRAIN_CYCLES) @(posedge clk_i);
    if (fail_count == 0 && pending == 0) begin
      $display("TB_OK");
    end else begin
      $display("TB_ERROR");
    end
    $finish;
  end

  // Hard stop in case the block hangs.
  initial begin : watchdog
    #(TIMEOUT);
    $display("TB_ERROR");
    $finish;
  end

endmodule
